[src/ryc_pkg.sv]
// Shared types, constants and coefficient tables for the RGB/YCbCr converter.
// Depends on nothing; every other source file imports it.
`default_nettype none

package ryc_pkg;

  typedef enum logic {
    DIR_YUV_TO_RGB = 1'b0,
    DIR_RGB_TO_YUV = 1'b1
  } dir_t;

  localparam int PIX_W      = 8;
  localparam int NUM_CH     = 3;
  localparam int OPND_W     = 9;   // signed operand after offset removal
  localparam int COEF_W     = 11;  // signed coefficient
  localparam int PROD_W     = 20;
  localparam int SUM_W      = 22;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [APB_ADDR_W-1:0] ADDR_DIRECTION = 3'd0;

  localparam int SHIFT_YUV_TO_RGB  = 8;
  // Luma keeps the usual scale; the chroma sums are quarter-scaled.
  localparam int SHIFT_RGB_TO_LUMA = 8;
  localparam int SHIFT_RGB_TO_YUV  = 10;

  localparam logic [PIX_W-1:0] LUMA_OFFSET   = 8'd16;
  localparam logic [PIX_W-1:0] CHROMA_OFFSET = 8'd128;
  localparam logic [PIX_W-1:0] PIX_MAX       = 8'd255;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Rows are output channels, columns are input components.
  localparam coef_t COEF_YUV_TO_RGB [NUM_CH][NUM_CH] = '{
    '{11'sd298,  11'sd0,    11'sd409},
    '{11'sd298, -11'sd100, -11'sd208},
    '{11'sd298,  11'sd517,  11'sd0}
  };

  localparam coef_t COEF_RGB_TO_YUV [NUM_CH][NUM_CH] = '{
    '{ 11'sd66,  11'sd129,  11'sd25},
    '{-11'sd38, -11'sd74,   11'sd112},
    '{ 11'sd112, -11'sd94, -11'sd18}
  };

  typedef struct packed {
    dir_t                               dir;
    logic [NUM_CH-1:0][PIX_W-1:0]       pix;
  } pix_item_t;

  typedef struct packed {
    dir_t                                   dir;
    logic [NUM_CH-1:0][NUM_CH-1:0][PROD_W-1:0] prod;
  } prod_item_t;

  typedef struct packed {
    dir_t                               dir;
    logic [NUM_CH-1:0][SUM_W-1:0]       sum;
  } sum_item_t;

endpackage

`default_nettype wire

[src/ryc_prod.sv]
// First pipeline stage: offset removal (YUV to RGB only) and the nine coefficient products.
// Depends on ryc_pkg.
`default_nettype none

module ryc_prod
  import ryc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire pix_item_t  in_item,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      prod_item_t out_item
);

  prod_item_t prod_next;

  always_comb begin
    logic signed [PROD_W-1:0] opnd;
    logic signed [PROD_W-1:0] coef;
    logic signed [OPND_W-1:0] opnd_n;
    logic        [PIX_W-1:0]  offs;
    prod_next.dir = in_item.dir;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int k = 0; k < NUM_CH; k++) begin
        offs = (k == 0) ? LUMA_OFFSET : CHROMA_OFFSET;
        if (in_item.dir == DIR_YUV_TO_RGB) begin
          opnd_n = $signed({1'b0, in_item.pix[k]}) - $signed({1'b0, offs});
          coef   = PROD_W'(COEF_YUV_TO_RGB[ch][k]);
        end else begin
          opnd_n = $signed({1'b0, in_item.pix[k]});
          coef   = PROD_W'(COEF_RGB_TO_YUV[ch][k]);
        end
        opnd = PROD_W'(opnd_n);
        prod_next.prod[ch][k] = opnd * coef;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item <= prod_next;
    end
  end

endmodule

`default_nettype wire

[src/ryc_sum.sv]
// Second pipeline stage: adds the three products of each output channel.
// Depends on ryc_pkg.
`default_nettype none

module ryc_sum
  import ryc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output      logic       in_ready,
  input  wire prod_item_t in_item,
  output      logic       out_valid,
  input  wire logic       out_ready,
  output      sum_item_t  out_item
);

  sum_item_t sum_next;

  always_comb begin
    logic signed [SUM_W-1:0] acc;
    logic signed [SUM_W-1:0] term;
    sum_next.dir = in_item.dir;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      acc = '0;
      for (int k = 0; k < NUM_CH; k++) begin
        term = SUM_W'($signed(in_item.prod[ch][k]));
        acc  = acc + term;
      end
      sum_next.sum[ch] = acc;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item <= sum_next;
    end
  end

endmodule

`default_nettype wire

[src/ryc_out.sv]
// Third pipeline stage: scaling shift, then clamping or offset, into the
// output register. Depends on ryc_pkg.
`default_nettype none

module ryc_out
  import ryc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire sum_item_t in_item,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      pix_item_t out_item
);

  pix_item_t pix_next;

  always_comb begin
    logic signed [SUM_W-1:0] shifted;
    logic        [PIX_W-1:0] offs;
    pix_next.dir = in_item.dir;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      offs = (ch == 0) ? LUMA_OFFSET : CHROMA_OFFSET;
      if (in_item.dir == DIR_YUV_TO_RGB) begin
        shifted = $signed(in_item.sum[ch]) >>> SHIFT_YUV_TO_RGB;
        if (shifted < 0) begin
          pix_next.pix[ch] = '0;
        end else if (shifted > $signed({{(SUM_W-PIX_W){1'b0}}, PIX_MAX})) begin
          pix_next.pix[ch] = PIX_MAX;
        end else begin
          pix_next.pix[ch] = shifted[PIX_W-1:0];
        end
      end else begin
        if (ch == 0) begin
          shifted = $signed(in_item.sum[ch]) >>> SHIFT_RGB_TO_LUMA;
        end else begin
          shifted = $signed(in_item.sum[ch]) >>> SHIFT_RGB_TO_YUV;
        end
        pix_next.pix[ch] = shifted[PIX_W-1:0] + offs;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_item <= pix_next;
    end
  end

endmodule

`default_nettype wire

[src/rgb_yuv_color_converter.sv]
// Top level of the BT.601 RGB/YCbCr pixel converter: register port and a
// three-stage pipeline. Depends on ryc_pkg, ryc_prod, ryc_sum and ryc_out.
//
//   Channel   Direction  Group                      Contents
//   input     in         s_tvalid/s_tready/s_tdata  one pixel, three components
//   output    out        m_tvalid/m_tready/m_tdata  one converted pixel
//   config    in/out     psel/penable/pwrite/...    direction register at 0x0
//
// One item is accepted in every clock cycle while the output is taken; each
// item passes the product, sum and output registers in turn (shift, clamp/offset).
// Reset empties the pipeline and sets the direction to YUV to RGB.
// Each stage holds its item while the stage after it is full and stalled, so
// a stall at the output backs up stage by stage; bubbles are squeezed out,
// and s_tready falls only when all three stages hold an item.
`default_nettype none

module rgb_yuv_color_converter
  import ryc_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  // Pixel input.
  input  wire logic                        s_tvalid,
  output      logic                        s_tready,
  input  wire logic [NUM_CH*PIX_W-1:0]     s_tdata,   // in_first, in_second, in_third
  // Pixel output.
  output      logic                        m_tvalid,
  input  wire logic                        m_tready,
  output      logic [NUM_CH*PIX_W-1:0]     m_tdata,   // out_first, out_second, out_third
  // Register port.
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [APB_ADDR_W-1:0]       paddr,
  input  wire logic [APB_DATA_W-1:0]       pwdata,
  output      logic [APB_DATA_W-1:0]       prdata,
  output      logic                        pready
);

  dir_t       direction;
  pix_item_t  in_item;
  prod_item_t prod_item;
  sum_item_t  sum_item;
  pix_item_t  out_item;
  logic       prod_valid;
  logic       prod_ready;
  logic       sum_valid;
  logic       sum_ready;

  // The direction register. Only bit 0 of the written data is kept; writes
  // to any other address are ignored.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_YUV_TO_RGB;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_DIRECTION)) begin
      direction <= dir_t'(pwdata[0]);
    end
  end

  always_comb begin
    if (paddr == ADDR_DIRECTION) begin
      prdata = {{(APB_DATA_W-1){1'b0}}, direction};
    end else begin
      prdata = '0;
    end
  end

  // The direction travels with every item, so each stage knows which
  // coefficient set and which final step applies to it.
  assign in_item.dir = direction;
  assign in_item.pix = s_tdata;

  ryc_prod u_prod (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_item  (prod_item)
  );

  ryc_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_item   (prod_item),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_item  (sum_item)
  );

  ryc_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .in_item   (sum_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (out_item)
  );

  assign m_tdata = out_item.pix;

  // The input is held off only when every stage is occupied.
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (prod_valid && sum_valid && m_tvalid))
    else $error("input stalled while the pipeline has a free stage");

  // An accepted item always lands in the first stage.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> prod_valid)
    else $error("accepted item missing from the first stage");

  // Forward conversion stays inside video range for any 8-bit input.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_item.dir == DIR_RGB_TO_YUV)) |->
      (out_item.pix[0] >= 8'd16) && (out_item.pix[0] <= 8'd235) &&
      (out_item.pix[1] >= 8'd100) && (out_item.pix[1] <= 8'd155) &&
      (out_item.pix[2] >= 8'd100) && (out_item.pix[2] <= 8'd155))
    else $error("RGB to YUV result outside its expected range");

endmodule

`default_nettype wire
